FILE: design/dns_name_wire_to_text_defines.svh
// Assertion macros shared by the checker of the DNS name text converter
`ifndef DNS_NAME_WIRE_TO_TEXT_DEFINES_SVH
`define DNS_NAME_WIRE_TO_TEXT_DEFINES_SVH

// Same-cycle implication, masked while in reset
`define DNSW_ASSERT(lbl, pre, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error("dnsw check failed");

// Next-cycle implication, masked while in reset
`define DNSW_ASSERT_NEXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error("dnsw check failed");

// Plain implication that also holds while reset is applied
`define DNSW_ASSERT_ALWAYS(lbl, pre, con) \
  lbl: assert property (@(posedge clk_i) (pre) |-> (con)) \
    else $error("dnsw check failed");

`endif

FILE: design/dnsw_pkg.sv
// Types, constants and codes for the DNS name wire to text converter
package dnsw_pkg;

  // Name limits
  localparam int unsigned MaxLabelLen = 63;
  localparam int unsigned MaxNameLen  = 255;

  // Most result words caused by one input word
  localparam int unsigned MaxRes = 5;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // Characters
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNul   = 8'h00;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_LABEL_LONG = 2'd1,
    ST_NAME_LONG  = 2'd2
  } status_e;

  // One result word
  typedef struct packed {
    logic [7:0] ch;
    status_e    st;
    logic       last;
  } res_t;

  // Parser state carried between input words
  typedef struct packed {
    logic [5:0] label_rem;
    logic [7:0] offset;
    logic       first;
    logic       err;
    logic       done;
  } state_t;

  localparam state_t StateReset = '{label_rem: 6'd0, offset: 8'd0, first: 1'b1,
                                    err: 1'b0, done: 1'b0};

endpackage

FILE: design/dnsw_encode.sv
// Combinational step: one wire byte and the parser state to result words and next state
module dnsw_encode (
  input  logic [7:0]        wire_byte_i,
  input  logic              name_start_i,
  input  dnsw_pkg::state_t  state_i,
  output dnsw_pkg::state_t  state_o,
  output dnsw_pkg::res_t    res_o [dnsw_pkg::MaxRes],
  output logic [dnsw_pkg::CntW-1:0] res_cnt_o
);
  import dnsw_pkg::*;

  state_t          st;
  logic [9:0]      name_sum;
  logic [7:0]      body [MaxRes];
  logic [CntW-1:0] body_cnt;
  logic            add_dot;
  logic [5:0]      rem_dec;
  logic [1:0]      tens;
  logic [5:0]      ones;
  logic            single;
  res_t            single_res;

  // Decimal digits of a byte at or below space (hundreds digit is always zero)
  always_comb begin
    if (wire_byte_i[5:0] >= 6'd30) begin
      tens = 2'd3;
    end else if (wire_byte_i[5:0] >= 6'd20) begin
      tens = 2'd2;
    end else if (wire_byte_i[5:0] >= 6'd10) begin
      tens = 2'd1;
    end else begin
      tens = 2'd0;
    end
    case (tens)
      2'd1:    ones = wire_byte_i[5:0] - 6'd10;
      2'd2:    ones = wire_byte_i[5:0] - 6'd20;
      2'd3:    ones = wire_byte_i[5:0] - 6'd30;
      default: ones = wire_byte_i[5:0];
    endcase
  end

  // Name length if this length byte opens a label (wide enough not to wrap)
  assign name_sum = {2'b00, st.offset} + 10'd1 + {2'b00, wire_byte_i};
  assign rem_dec  = st.label_rem - 6'd1;

  // State update and result list
  always_comb begin
    st         = name_start_i ? StateReset : state_i;
    state_o    = st;
    for (int i = 0; i < MaxRes; i++) begin
      body[i] = ChNul;
    end
    body_cnt   = '0;
    add_dot    = 1'b0;
    single     = 1'b0;
    single_res = '{ch: ChNul, st: ST_OK, last: 1'b0};

    if (st.err || st.done) begin
      // dropping until the next name start
    end else if (st.label_rem == 6'd0) begin
      state_o.first = 1'b0;
      if (wire_byte_i == 8'd0) begin
        // end of name: root gives a dot first
        state_o.done = 1'b1;
        add_dot      = st.first;
        single       = 1'b1;
        single_res   = '{ch: ChNul, st: ST_OK, last: 1'b1};
      end else if (name_sum >= 10'(MaxNameLen)) begin
        state_o.err = 1'b1;
        single      = 1'b1;
        single_res  = '{ch: ChNul, st: ST_NAME_LONG, last: 1'b1};
      end else if (wire_byte_i > 8'(MaxLabelLen)) begin
        state_o.err = 1'b1;
        single      = 1'b1;
        single_res  = '{ch: ChNul, st: ST_LABEL_LONG, last: 1'b1};
      end else begin
        state_o.label_rem = wire_byte_i[5:0];
        state_o.offset    = st.offset + 8'd1;
      end
    end else begin
      // label character with escaping
      if (wire_byte_i == ChDot || wire_byte_i == ChBsl) begin
        body[0]  = ChBsl;
        body[1]  = wire_byte_i;
        body_cnt = CntW'(2);
      end else if (wire_byte_i <= ChSpace) begin
        body[0]  = ChBsl;
        body[1]  = ChZero;
        body[2]  = ChZero + {6'd0, tens};
        body[3]  = ChZero + {2'd0, ones};
        body_cnt = CntW'(4);
      end else begin
        body[0]  = wire_byte_i;
        body_cnt = CntW'(1);
      end
      state_o.label_rem = rem_dec;
      state_o.offset    = st.offset + 8'd1;
      add_dot           = (rem_dec == 6'd0);
    end
  end

  // Pack body, trailing dot and closing word into the result list
  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      if (single) begin
        if (add_dot && i == 0) begin
          res_o[i] = '{ch: ChDot, st: ST_OK, last: 1'b0};
        end else begin
          res_o[i] = single_res;
        end
      end else if (CntW'(i) < body_cnt) begin
        res_o[i] = '{ch: body[i], st: ST_OK, last: 1'b0};
      end else begin
        res_o[i] = '{ch: ChDot, st: ST_OK, last: 1'b0};
      end
    end
    if (single) begin
      res_cnt_o = add_dot ? CntW'(2) : CntW'(1);
    end else begin
      res_cnt_o = body_cnt + {{(CntW-1){1'b0}}, add_dot};
    end
  end

endmodule

FILE: design/dns_name_wire_to_text.sv
// Top level of the DNS wire-format name to dotted text converter
//
// Input channel s_axis: one wire byte per word, tuser set on the first byte
// of each name. Output channel m_axis: one text character per word with its
// status; tlast marks the closing NUL or the single error word of a name.
// The parser state moves on as each byte is accepted; the results of that
// byte are loaded into a five-entry result register and shown from the next
// cycle. Throughput: one byte per cycle while each byte yields at most one
// result and the receiver does not stall. A byte that yields several
// results holds the input until they drain; the next byte is taken in the
// cycle the last of them leaves, so the rate is set by the single output
// port draining the result register.
// Reset clears the parser to the start of a name and empties the result
// register. When the receiver stalls, the current word holds and input is
// refused until the last queued word is being taken.
module dns_name_wire_to_text (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] wire_byte
  input  logic        s_axis_tuser_i,  // [0] name_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [7:0] text_char, [9:8] status, rest zero
  output logic        m_axis_tlast_o
);
  import dnsw_pkg::*;

  state_t          state_q, state_d;
  res_t            res_q [MaxRes];
  res_t            res_d [MaxRes];
  res_t            enc_res [MaxRes];
  logic [CntW-1:0] cnt_q, cnt_d, enc_cnt;
  logic            in_acc, out_pop;

  dnsw_encode u_enc (
    .wire_byte_i  (s_axis_tdata_i),
    .name_start_i (s_axis_tuser_i),
    .state_i      (state_q),
    .state_o      (state_d),
    .res_o        (enc_res),
    .res_cnt_o    (enc_cnt)
  );

  // Handshakes
  assign out_pop         = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Result register: load on accept, shift down on each word taken
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = res_q[i];
    end
    if (in_acc) begin
      cnt_d = enc_cnt;
      for (int i = 0; i < MaxRes; i++) begin
        res_d[i] = enc_res[i];
      end
    end else if (out_pop) begin
      cnt_d = cnt_q - CntW'(1);
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_d[i] = res_q[i + 1];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        state_q <= state_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      res_q[i] <= res_d[i];
    end
  end

  // Output word
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {6'd0, res_q[0].st, res_q[0].ch};
  assign m_axis_tlast_o  = res_q[0].last;

endmodule

FILE: design/dnsw_checker.sv
// Port-level checker for the DNS name text converter, bound to the top level
`include "dns_name_wire_to_text_defines.svh"

module dnsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // Nothing is shown while reset is held
  `DNSW_ASSERT_ALWAYS(a_rst_quiet, !rst_ni, !m_axis_tvalid_o)

  // A stalled output word holds
  `DNSW_ASSERT_NEXT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // Input is refused while a stalled word is shown
  `DNSW_ASSERT(a_no_accept_on_stall, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o)

  // An error word closes the name and carries a zero character
  `DNSW_ASSERT(a_err_word, m_axis_tvalid_o && (m_axis_tdata_o[9:8] != 2'd0),
    m_axis_tlast_o && (m_axis_tdata_o[7:0] == 8'd0) && (m_axis_tdata_o[9:8] != 2'd3))

  // A word that is not last is never a NUL
  `DNSW_ASSERT(a_nul_last, m_axis_tvalid_o && (m_axis_tdata_o[7:0] == 8'd0), m_axis_tlast_o)

  logic unused_in;
  assign unused_in = s_axis_tvalid_i ^ (^s_axis_tdata_i) ^ s_axis_tuser_i
                     ^ (^m_axis_tdata_o[15:10]);

endmodule

bind dns_name_wire_to_text dnsw_checker u_dnsw_checker (.*);
